### sv/sliding_complex_correlator_macros.svh
// Assertion macros shared by the correlator modules.
`ifndef SLIDING_COMPLEX_CORRELATOR_MACROS_SVH
`define SLIDING_COMPLEX_CORRELATOR_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define SCC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset-qualified.
`define SCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/scc_pkg.sv
// Shared constants and types of the sliding complex correlator.
`timescale 1ns / 1ps

package scc_pkg;

	// Default sizes
	localparam int MAX_REF_LEN_DEF = 128;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int POS_W           = 32;

	// Input item operations
	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_SAMPLE  = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	// Correlator control states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ACC  = 3'b010,
		ST_MAG  = 3'b100
	} ctl_state_t;

	// Magnitude unit states
	typedef enum logic [2:0] {
		MS_IDLE = 3'b001,
		MS_SQR  = 3'b010,
		MS_ROOT = 3'b100
	} mag_state_t;

endpackage

### sv/scc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module scc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### sv/scc_cell.sv
// One window cell: holds a complex sample and takes its neighbor's on advance.
`timescale 1ns / 1ps

module scc_cell #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             advance,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] smp_q;

	// Take the neighbor's sample, else hold
	always_ff @(posedge clk) begin
		if (advance) begin
			smp_q <= d;
		end
	end

	assign q = smp_q;

endmodule

### sv/scc_mag.sv
// Magnitude unit: split-product power of a complex sum, then digit-by-digit square root.
`timescale 1ns / 1ps

`include "sliding_complex_correlator_macros.svh"

module scc_mag
	import scc_pkg::*;
#(
	parameter int ABS_W = 39
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ABS_W:0]   sr,
	input  logic signed [ABS_W:0]   si,
	output logic                    res_valid,
	output logic [ABS_W-1:0]        res
);

	localparam int HW   = (ABS_W + 1) / 2;
	localparam int PW   = 2 * ABS_W;
	localparam int RMW  = ABS_W + 3;
	localparam int IT_W = $clog2(ABS_W);
	localparam logic [2:0] SQ_LAST = 3'd6;

	mag_state_t        state_q;
	logic [2:0]        stp_q;
	logic [IT_W-1:0]   it_q;
	logic              pv_s1;
	logic [2:0]        kind_s1;
	logic [2*HW-1:0]   prod_s1;
	logic [ABS_W-1:0]  abs_r_q;
	logic [ABS_W-1:0]  abs_i_q;
	logic [PW-1:0]     pwr_q;
	logic [RMW-1:0]    rem_q;
	logic [ABS_W-1:0]  root_q;
	logic              res_valid_q;

	logic [HW-1:0]     op_x;
	logic [HW-1:0]     op_y;
	logic              issue;
	logic [PW-1:0]     pp_shift;
	logic [RMW-1:0]    cand;
	logic [RMW-1:0]    trial;
	logic              fits;
	logic              last_it;

	// Pick the partial product for this step: lo*lo, hi*lo (doubled), hi*hi
	always_comb begin
		op_x = '0;
		op_y = '0;
		case (stp_q)
			3'd0: begin
				op_x = abs_r_q[HW-1:0];
				op_y = abs_r_q[HW-1:0];
			end
			3'd1: begin
				op_x = HW'(abs_r_q[ABS_W-1:HW]);
				op_y = abs_r_q[HW-1:0];
			end
			3'd2: begin
				op_x = HW'(abs_r_q[ABS_W-1:HW]);
				op_y = HW'(abs_r_q[ABS_W-1:HW]);
			end
			3'd3: begin
				op_x = abs_i_q[HW-1:0];
				op_y = abs_i_q[HW-1:0];
			end
			3'd4: begin
				op_x = HW'(abs_i_q[ABS_W-1:HW]);
				op_y = abs_i_q[HW-1:0];
			end
			3'd5: begin
				op_x = HW'(abs_i_q[ABS_W-1:HW]);
				op_y = HW'(abs_i_q[ABS_W-1:HW]);
			end
			default: begin
				op_x = '0;
				op_y = '0;
			end
		endcase
	end

	assign issue = (state_q == MS_SQR) && (stp_q != SQ_LAST);

	// Weight the registered partial product
	always_comb begin
		case (kind_s1) inside
			3'd1, 3'd4: pp_shift = PW'(prod_s1) << (HW + 1);
			3'd2, 3'd5: pp_shift = PW'(prod_s1) << (2 * HW);
			default:    pp_shift = PW'(prod_s1);
		endcase
	end

	// One root digit per cycle
	assign cand    = {rem_q[RMW-3:0], pwr_q[PW-1 -: 2]};
	assign trial   = RMW'({root_q, 2'b01});
	assign fits    = (cand >= trial);
	assign last_it = (it_q == IT_W'(ABS_W - 1));

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= MS_IDLE;
			stp_q       <= '0;
			it_q        <= '0;
			pv_s1       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			pv_s1 <= issue;
			unique case (state_q)
				MS_IDLE: begin
					if (start) begin
						state_q     <= MS_SQR;
						stp_q       <= '0;
						res_valid_q <= 1'b0;
					end
				end
				MS_SQR: begin
					if (stp_q == SQ_LAST) begin
						state_q <= MS_ROOT;
						it_q    <= '0;
					end else begin
						stp_q <= stp_q + 3'd1;
					end
				end
				MS_ROOT: begin
					it_q <= it_q + IT_W'(1);
					if (last_it) begin
						state_q     <= MS_IDLE;
						res_valid_q <= 1'b1;
					end
				end
				default: state_q <= MS_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start && (state_q == MS_IDLE)) begin
			abs_r_q <= sr[ABS_W] ? ABS_W'(-sr) : ABS_W'(sr);
			abs_i_q <= si[ABS_W] ? ABS_W'(-si) : ABS_W'(si);
			pwr_q   <= '0;
		end else if (state_q == MS_ROOT) begin
			pwr_q <= pwr_q << 2;
		end else if (pv_s1) begin
			pwr_q <= pwr_q + pp_shift;
		end
		prod_s1 <= op_x * op_y;
		kind_s1 <= stp_q;
		if (state_q == MS_SQR && stp_q == SQ_LAST) begin
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == MS_ROOT) begin
			rem_q  <= fits ? (cand - trial) : cand;
			root_q <= {root_q[ABS_W-2:0], fits};
		end
	end

	assign res_valid = res_valid_q;
	assign res       = root_q;

	`SCC_ASSERT_IMPL(a_start_idle, clk, arst_n, start, state_q == MS_IDLE, "start while busy")
	`SCC_ASSERT_IMPL(a_valid_idle, clk, arst_n, res_valid_q, state_q == MS_IDLE, "result valid while busy")
	`SCC_ASSERT_NEXT(a_root_done, clk, arst_n, (state_q == MS_ROOT) && last_it, res_valid_q, "root end without result")

endmodule

### sv/sliding_complex_correlator.sv
// Sliding complex correlator top level. Coefficients are loaded by index into a
// coefficient memory (operation load); samples (operation sample) shift into a
// ring of MAX_REF_LEN window cells; restart clears the fill and position counts.
// Loads, restarts and samples that do not complete a window leave the correlator
// ready for the next item. A sample that completes a window of reference_length
// samples rotates the ring once around, feeding one tap per cycle past the
// coefficient memory read port and a four-multiplier complex MAC, then the
// magnitude unit forms the power and extracts the root one bit per cycle. The
// output register lets the next item enter while a result waits.
// A reference_length of 0 acts as 1 and one above MAX_REF_LEN as MAX_REF_LEN.
`timescale 1ns / 1ps

`include "sliding_complex_correlator_macros.svh"

module sliding_complex_correlator
	import scc_pkg::*;
#(
	parameter int MAX_REF_LEN = MAX_REF_LEN_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int IW    = $clog2(MAX_REF_LEN),
	localparam int LW    = $clog2(MAX_REF_LEN + 1),
	localparam int ABS_W = 2 * SAMPLE_BITS + $clog2(MAX_REF_LEN)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [LW-1:0]                 cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    operation,
	input  logic [IW-1:0]                 coef_index,
	input  logic signed [SAMPLE_BITS-1:0] real_part,
	input  logic signed [SAMPLE_BITS-1:0] imag_part,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ABS_W-1:0]              magnitude,
	output logic [POS_W-1:0]              window_start
);

	localparam int SB    = SAMPLE_BITS;
	localparam int SMP_W = 2 * SB;
	localparam int ACC_W = ABS_W + 1;
	localparam int CW    = $clog2(MAX_REF_LEN + 3);

	ctl_state_t         state_q;
	logic [LW-1:0]      len_q;
	logic [LW-1:0]      fill_q;
	logic [POS_W-1:0]   pos_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      base_q;
	logic [POS_W-1:0]   wst_q;
	logic               tap_s1;
	logic               tap_s2;
	logic signed [SB-1:0]    a_s1;
	logic signed [SB-1:0]    b_s1;
	logic signed [SMP_W-1:0] ap_s2;
	logic signed [SMP_W-1:0] bq_s2;
	logic signed [SMP_W-1:0] bp_s2;
	logic signed [SMP_W-1:0] aq_s2;
	logic signed [ACC_W-1:0] sr_q;
	logic signed [ACC_W-1:0] si_q;
	logic               out_valid_q;
	logic [ABS_W-1:0]   out_mag_q;
	logic [POS_W-1:0]   out_pos_q;

	logic               in_take;
	op_t                op;
	logic               do_load;
	logic               do_sample;
	logic               do_restart;
	logic [LW-1:0]      fill_inc;
	logic [POS_W-1:0]   pos_inc;
	logic               go_acc;
	logic               rotate;
	logic               advance;
	logic               tap;
	logic               mag_start;
	logic               mag_valid;
	logic [ABS_W-1:0]   mag_res;
	logic               load_out;
	logic               out_take;
	logic [LW-1:0]      cfg_len;
	logic [SMP_W-1:0]   new_smp;
	logic [SMP_W-1:0]   coef;
	logic               ram_we;
	logic [IW-1:0]      ram_raddr;
	logic signed [SB-1:0] coef_p;
	logic signed [SB-1:0] coef_q;
	logic [SMP_W-1:0]   cell_d [MAX_REF_LEN];
	logic [SMP_W-1:0]   cell_q [MAX_REF_LEN];

	// Item decode
	assign in_ready   = (state_q == ST_IDLE);
	assign in_take    = in_valid && in_ready;
	assign op         = op_t'(operation);
	assign do_load    = in_take && (op == OP_LOAD);
	assign do_sample  = in_take && (op == OP_SAMPLE);
	assign do_restart = in_take && (op == OP_RESTART);

	assign fill_inc = (fill_q < LW'(MAX_REF_LEN)) ? fill_q + LW'(1) : fill_q;
	assign pos_inc  = pos_q + POS_W'(1);
	assign go_acc   = do_sample && (fill_inc >= len_q);

	// Clamp the written window length
	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_len = LW'(1);
		end else if (cfg_wdata > LW'(MAX_REF_LEN)) begin
			cfg_len = LW'(MAX_REF_LEN);
		end else begin
			cfg_len = cfg_wdata;
		end
	end

	// Coefficient memory
	assign ram_we    = do_load && ({1'b0, coef_index} < (IW + 1)'(MAX_REF_LEN));
	assign ram_raddr = IW'(cnt_q - base_q);

	scc_ram #(
		.WIDTH(SMP_W),
		.DEPTH(MAX_REF_LEN)
	) u_coef_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(coef_index),
		.wdata({real_part, imag_part}),
		.raddr(ram_raddr),
		.rdata(coef)
	);

	assign coef_p = coef[SMP_W-1:SB];
	assign coef_q = coef[SB-1:0];

	// Window ring: shift in on a sample, rotate once around per result
	assign rotate  = (state_q == ST_ACC) && (cnt_q < CW'(MAX_REF_LEN));
	assign advance = do_sample || rotate;
	assign new_smp = {real_part, imag_part};
	assign tap     = rotate && (cnt_q >= base_q);

	for (genvar i = 0; i < MAX_REF_LEN; i++) begin : g_cell
		if (i == MAX_REF_LEN - 1) begin : g_head
			assign cell_d[i] = do_sample ? new_smp : cell_q[0];
		end else begin : g_body
			assign cell_d[i] = cell_q[i+1];
		end
		scc_cell #(
			.WIDTH(SMP_W)
		) u_cell (
			.clk    (clk),
			.advance(advance),
			.d      (cell_d[i]),
			.q      (cell_q[i])
		);
	end

	assign mag_start = (state_q == ST_ACC) && (cnt_q == CW'(MAX_REF_LEN + 2));

	scc_mag #(
		.ABS_W(ABS_W)
	) u_mag (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mag_start),
		.sr       (sr_q),
		.si       (si_q),
		.res_valid(mag_valid),
		.res      (mag_res)
	);

	// Output register handshake
	assign out_take = out_valid_q && out_ready;
	assign load_out = (state_q == ST_MAG) && mag_valid && (!out_valid_q || out_ready);

	// Control state, counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= LW'(MAX_REF_LEN);
			fill_q      <= '0;
			pos_q       <= '0;
			cnt_q       <= '0;
			tap_s1      <= 1'b0;
			tap_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				len_q <= cfg_len;
			end
			tap_s1 <= tap;
			tap_s2 <= tap_s1;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (do_sample) begin
						fill_q <= fill_inc;
						pos_q  <= pos_inc;
					end else if (do_restart) begin
						fill_q <= '0;
						pos_q  <= '0;
					end
					if (go_acc) begin
						state_q <= ST_ACC;
						cnt_q   <= '0;
					end
				end
				ST_ACC: begin
					cnt_q <= cnt_q + CW'(1);
					if (mag_start) begin
						state_q <= ST_MAG;
					end
				end
				ST_MAG: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// MAC pipeline: tap select, products, accumulate
	always_ff @(posedge clk) begin
		if (go_acc) begin
			base_q <= CW'(LW'(MAX_REF_LEN) - len_q);
			wst_q  <= pos_inc - POS_W'(len_q);
		end
		a_s1  <= cell_q[0][SMP_W-1:SB];
		b_s1  <= cell_q[0][SB-1:0];
		ap_s2 <= a_s1 * coef_p;
		bq_s2 <= b_s1 * coef_q;
		bp_s2 <= b_s1 * coef_p;
		aq_s2 <= a_s1 * coef_q;
		if (go_acc) begin
			sr_q <= '0;
			si_q <= '0;
		end else if (tap_s2) begin
			sr_q <= sr_q + ACC_W'(ap_s2) + ACC_W'(bq_s2);
			si_q <= si_q + ACC_W'(bp_s2) - ACC_W'(aq_s2);
		end
		if (load_out) begin
			out_mag_q <= mag_res;
			out_pos_q <= wst_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign magnitude    = out_mag_q;
	assign window_start = out_pos_q;

	`SCC_ASSERT_IMPL(a_fill_bound, clk, arst_n, 1'b1, fill_q <= LW'(MAX_REF_LEN), "fill count past window")
	`SCC_ASSERT_IMPL(a_acc_full, clk, arst_n, state_q == ST_ACC, fill_q >= len_q, "sum over partial window")
	`SCC_ASSERT_NEXT(a_start_mag, clk, arst_n, mag_start, (state_q == ST_MAG) && !mag_valid, "magnitude start out of step")

endmodule
